// File: rtl/core/sph_pkg.sv
// Package for the secret-prefix SHA-256 hasher: sizes, codes, round constants.
// No dependencies.
package sph_pkg;
  localparam int SECRET_BYTES  = 20;
  localparam int MESSAGE_BYTES = 32;
  localparam int DIGEST_BYTES  = 32;
  localparam int BLOCK_BYTES   = SECRET_BYTES + MESSAGE_BYTES;
  localparam int STORE_DEPTH   = 2 * SECRET_BYTES;
  localparam int STORE_AW      = $clog2(STORE_DEPTH);
  localparam int MSG_AW        = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1;
  localparam logic [7:0] CMD_SET  = 8'h01;
  localparam logic [7:0] CMD_HASH = 8'h02;
  localparam logic [7:0] ACK_BYTE = 8'h01;
  localparam logic [15:0] BIT_LEN = 16'(BLOCK_BYTES * 8);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SECRET, ST_MESSAGE, ST_CLEAR, ST_LOAD, ST_ROUND, ST_FINAL, ST_OUT, ST_ACK
  } state_t;

  typedef struct packed {
    logic       start;
    logic [7:0] blk_byte;
    logic       blk_valid;
  } core_ctl_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
          32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
          32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
          32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
          32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
          32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
          32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
          32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
          32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
          32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
          32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[i];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage

// File: rtl/core/sph_if.sv
// Byte stream channel interfaces.
// Depends on nothing.
interface sph_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sph_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last;
  modport source (output valid, output tx_byte, output last, input ready);
  modport sink   (input valid, input tx_byte, input last, output ready);
endinterface

// File: rtl/core/sph_core.sv
// SHA-256 compression of one block, one round per cycle, message schedule
// in a 16-word sliding window. Depends on sph_pkg.
module sph_core (
  input  logic              clk,
  input  logic              rst_n,
  input  sph_pkg::core_ctl_t ctl,
  output logic              done,
  output logic [255:0]      digest
);
  import sph_pkg::*;

  logic [31:0] w_r [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [6:0]  rnd_r;
  logic [5:0]  fill_r;
  logic        busy_r, done_r;
  logic [255:0] dig_r;
  logic [31:0] s0, s1, wn, t1, t2, wcur;

  always_comb begin
    wcur = w_r[0];
    s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wn = w_r[0] + s0 + w_r[9] + s1;
    t1 = h_r + (rotr(e_r, 6) ^ rotr(e_r, 11) ^ rotr(e_r, 25)) + ((e_r & f_r) ^ (~e_r & g_r))
         + round_k(rnd_r[5:0]) + wcur;
    t2 = (rotr(a_r, 2) ^ rotr(a_r, 13) ^ rotr(a_r, 22)) ^ 32'h0;
    t2 = t2 + ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
      fill_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        fill_r <= '0;
        busy_r <= 1'b0;
      end
      if (ctl.blk_valid) begin
        w_r[fill_r[5:2]] <= {w_r[fill_r[5:2]][23:0], ctl.blk_byte};
        fill_r <= fill_r + 6'd1;
        if (fill_r == 6'd63) begin
          busy_r <= 1'b1;
          rnd_r  <= '0;
          {a_r, b_r, c_r, d_r} <= {init_h(0), init_h(1), init_h(2), init_h(3)};
          {e_r, f_r, g_r, h_r} <= {init_h(4), init_h(5), init_h(6), init_h(7)};
        end
      end
      if (busy_r) begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= wn;
        h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
        d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
        rnd_r <= rnd_r + 7'd1;
        if (rnd_r == 7'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          dig_r <= {init_h(0) + t1 + t2, init_h(1) + a_r, init_h(2) + b_r, init_h(3) + c_r,
                    init_h(4) + d_r + t1, init_h(5) + e_r, init_h(6) + f_r, init_h(7) + g_r};
        end
      end
    end
  end

  assign done   = done_r;
  assign digest = dig_r;

`ifndef SYNTH
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !ctl.blk_valid) else $error("block byte during rounds");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held");
  a_done_after_round: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without rounds");
`endif
endmodule

// File: rtl/core/secret_prefix_sha256_hasher.sv
// Top level: command parser, secret store and message memories, reply sequencer.
// Depends on sph_pkg, sph_if, sph_core.
//   channel  dir  payload            beat
//   in       in   rx_byte[7:0]       valid & ready
//   out      out  tx_byte[7:0],last  valid & ready
// One byte per cycle while collecting, when in_ch.valid is high. After the last
// message byte: a load pass (52 memory reads via a registered read port, then 12
// padding bytes), then 64 rounds in sph_core, then the digest is registered and
// sent as 32 reply beats. Input stalls until the reply is done. Reset starts a
// clearing pass over all 40 secret store bytes; no bytes taken then.
module secret_prefix_sha256_hasher (
  input logic clk,
  input logic rst_n,
  sph_rx_if.sink   in_ch,
  sph_tx_if.source out_ch
);
  import sph_pkg::*;

  logic [7:0] sec_mem [STORE_DEPTH];
  logic [7:0] msg_mem [MESSAGE_BYTES];
  state_t state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic bank_r, bank_nxt;
  logic [7:0] rd_r;
  logic rd_v_r, rd_v_nxt;
  logic [255:0] dig_r;
  logic core_done;
  logic [255:0] core_dig;
  core_ctl_t ctl;
  logic sec_we, in_fire, out_fire;
  logic [STORE_AW-1:0] sec_wa, sec_ra;
  logic [MSG_AW-1:0] msg_ra;
  logic [7:0] sec_wd;
  logic rd_sec;
  logic rd_sec_r;
  logic [7:0] pad_byte;

  assign in_fire  = in_ch.valid & in_ch.ready;
  assign out_fire = out_ch.valid & out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    bank_nxt = bank_r;
    in_ch.ready = 1'b0;
    sec_we = 1'b0;
    sec_wa = STORE_AW'(cnt_r);
    sec_wd = in_ch.rx_byte;
    rd_v_nxt = 1'b0;
    rd_sec = 1'b0;
    sec_ra = '0;
    msg_ra = '0;
    unique case (state_r)
      ST_CLEAR: begin
        sec_we = 1'b1;
        sec_wd = 8'h00;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(STORE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
          cnt_nxt = '0;
        end
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        cnt_nxt = '0;
        if (in_ch.valid && in_ch.rx_byte == CMD_SET) state_nxt = ST_SECRET;
        else if (in_ch.valid && in_ch.rx_byte == CMD_HASH) state_nxt = ST_MESSAGE;
      end
      ST_SECRET: begin
        in_ch.ready = 1'b1;
        sec_wa = STORE_AW'(7'(bank_r ? 0 : SECRET_BYTES) + cnt_r);
        if (in_ch.valid) begin
          sec_we = 1'b1;
          cnt_nxt = cnt_r + 7'd1;
          if (cnt_r == 7'(SECRET_BYTES - 1)) begin
            bank_nxt = ~bank_r;
            state_nxt = ST_ACK;
          end
        end
      end
      ST_ACK: if (out_fire) state_nxt = ST_IDLE;
      ST_MESSAGE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          cnt_nxt = cnt_r + 7'd1;
          if (cnt_r == 7'(MESSAGE_BYTES - 1)) begin
            state_nxt = ST_LOAD;
            cnt_nxt = '0;
          end
        end
      end
      ST_LOAD: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r < 7'(BLOCK_BYTES)) begin
          rd_v_nxt = 1'b1;
          rd_sec = cnt_r < 7'(SECRET_BYTES);
          sec_ra = STORE_AW'(7'(bank_r ? SECRET_BYTES : 0) + cnt_r);
          msg_ra = MSG_AW'(cnt_r - 7'(SECRET_BYTES));
        end
        if (cnt_r == 7'd64) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: if (core_done) begin
        state_nxt = ST_OUT;
        cnt_nxt = '0;
      end
      ST_OUT: if (out_fire) begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(DIGEST_BYTES - 1)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (sec_we) sec_mem[sec_wa] <= sec_wd;
    if (state_r == ST_MESSAGE && in_fire) msg_mem[MSG_AW'(cnt_r)] <= in_ch.rx_byte;
    rd_r <= rd_sec ? sec_mem[sec_ra] : msg_mem[msg_ra];
    rd_sec_r <= rd_sec;
    if (core_done) dig_r <= core_dig;
    else if (out_fire) dig_r <= {dig_r[247:0], 8'h00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r <= '0;
      bank_r <= 1'b0;
      rd_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      bank_r <= bank_nxt;
      rd_v_r <= rd_v_nxt;
    end
  end

  // padding bytes follow the memory reads and, like the registered read data, trail the address count
  always_comb begin
    unique case (cnt_r)
      7'(BLOCK_BYTES + 1): pad_byte = 8'h80;
      7'd63:               pad_byte = BIT_LEN[15:8];
      7'd64:               pad_byte = BIT_LEN[7:0];
      default:             pad_byte = 8'h00;
    endcase
  end

  assign ctl.start = (state_r == ST_LOAD) && (cnt_r == 7'd0);
  assign ctl.blk_valid = rd_v_r || ((state_r == ST_LOAD) && (cnt_r > 7'(BLOCK_BYTES)));
  assign ctl.blk_byte = rd_v_r ? rd_r : pad_byte;

  sph_core u_core (.clk(clk), .rst_n(rst_n), .ctl(ctl), .done(core_done), .digest(core_dig));

  assign out_ch.valid = (state_r == ST_ACK) || (state_r == ST_OUT);
  assign out_ch.tx_byte = (state_r == ST_ACK) ? ACK_BYTE : dig_r[255:248];
  assign out_ch.last = (state_r == ST_ACK) || (cnt_r == 7'(DIGEST_BYTES - 1));

`ifndef SYNTH
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("input open during reply");
  a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACK && $past(state_r) == ST_SECRET) |-> bank_r != $past(bank_r))
    else $error("bank not flipped");
  a_rd_sec_load: assert property (@(posedge clk) disable iff (!rst_n)
    rd_sec_r |-> rd_v_r) else $error("secret read outside load");
`endif
endmodule

// File: dv/sph_tb_if.sv
// Testbench-side note: channel interfaces come from the RTL file sph_if.sv.
// Depends on nothing. This file only declares a tiny helper package.
`timescale 1ns / 1ps
package sph_tb_pkg;
  typedef struct {
    logic [7:0] tx_byte;
    logic       last;
  } reply_beat_t;
endpackage

// File: dv/tb_secret_prefix_sha256_hasher.sv
// Testbench for secret_prefix_sha256_hasher: drives command/secret/message byte
// streams, predicts acks and SHA-256 digests, and checks every reply beat.
// Depends on sph_pkg, sph_if, sph_tb_pkg and the RTL top level.
`timescale 1ns / 1ps
module tb_secret_prefix_sha256_hasher;
  import sph_pkg::*;
  import sph_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  sph_rx_if in_ch ();
  sph_tx_if out_ch ();

  secret_prefix_sha256_hasher i_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  logic [7:0]  rx_pending [$];
  reply_beat_t reply_expected [$];
  int          n_errors = 0;
  int          n_acks = 0;
  int          n_digests = 0;
  int          n_beats = 0;
  bit          calm = 1'b0;
  bit          hold_tx = 1'b0;
  bit          in_acc = 1'b0;

  // predictor state
  logic [1:0]  pr_phase = 2'd0;
  logic [5:0]  pr_count = '0;
  logic        pr_bank = 1'b0;
  logic [7:0]  pr_secret [STORE_DEPTH];
  logic [7:0]  pr_msg [MESSAGE_BYTES];

  initial foreach (pr_secret[i]) pr_secret[i] = '0;

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic push_digest();
    logic [7:0]  blk [64];
    logic [31:0] w [64];
    logic [31:0] h [8];
    logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
    reply_beat_t rb;
    for (int i = 0; i < 64; i++) blk[i] = '0;
    for (int i = 0; i < SECRET_BYTES; i++) blk[i] = pr_secret[pr_bank * SECRET_BYTES + i];
    for (int i = 0; i < MESSAGE_BYTES; i++) blk[SECRET_BYTES + i] = pr_msg[i];
    blk[BLOCK_BYTES] = 8'h80;
    blk[62] = BIT_LEN[15:8];
    blk[63] = BIT_LEN[7:0];
    for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) h[i] = init_h(3'(i));
    a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4]; f = h[5]; g = h[6]; hh = h[7];
    for (int i = 0; i < 64; i++) begin
      t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + round_k(6'(i)) + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      hh = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
    for (int i = 0; i < DIGEST_BYTES; i++) begin
      rb.tx_byte = h[i/4][31 - 8*(i%4) -: 8];
      rb.last = (i == DIGEST_BYTES - 1);
      reply_expected.push_back(rb);
    end
  endtask

  task automatic predict_byte(logic [7:0] rx);
    reply_beat_t rb;
    if (pr_phase == 2'd1) begin
      pr_secret[(!pr_bank) * SECRET_BYTES + pr_count] = rx;
      pr_count++;
      if (pr_count >= SECRET_BYTES) begin
        pr_bank = !pr_bank;
        pr_phase = 2'd0;
        pr_count = '0;
        rb.tx_byte = ACK_BYTE;
        rb.last = 1'b1;
        reply_expected.push_back(rb);
        n_acks++;
      end
    end else if (pr_phase == 2'd2) begin
      pr_msg[pr_count] = rx;
      pr_count++;
      if (pr_count >= MESSAGE_BYTES) begin
        push_digest();
        pr_phase = 2'd0;
        pr_count = '0;
        n_digests++;
      end
    end else begin
      pr_count = '0;
      pr_phase = (rx == CMD_SET) ? 2'd1 : (rx == CMD_HASH) ? 2'd2 : 2'd0;
    end
  endtask

  // driver
  initial begin
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
  end
  always @(posedge clk) in_acc <= rst_n && in_ch.valid && in_ch.ready;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_acc) begin
      if (in_acc) void'(rx_pending.pop_front());
      if (rx_pending.size() > 0 && !hold_tx && (calm || $urandom_range(99) >= 15)) begin
        in_ch.valid <= 1'b1;
        in_ch.rx_byte <= rx_pending[0];
      end else begin
        in_ch.valid <= 1'b0;
        in_ch.rx_byte <= 8'($urandom);
      end
    end
  end

  always @(posedge clk)
    if (rst_n && in_ch.valid && in_ch.ready) predict_byte(in_ch.rx_byte);

  // monitor
  initial out_ch.ready = 1'b0;
  always @(negedge clk)
    out_ch.ready <= rst_n && (calm || $urandom_range(99) >= 15);

  always @(posedge clk) begin
    reply_beat_t rb;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_beats++;
      if (reply_expected.size() == 0) begin
        $error("unexpected beat tx_byte=%0h last=%0b", out_ch.tx_byte, out_ch.last);
        n_errors++;
      end else begin
        rb = reply_expected.pop_front();
        if (out_ch.tx_byte !== rb.tx_byte) begin
          $error("tx_byte expected %0h actual %0h", rb.tx_byte, out_ch.tx_byte);
          n_errors++;
        end
        if (out_ch.last !== rb.last) begin
          $error("last expected %0b actual %0b", rb.last, out_ch.last);
          n_errors++;
        end
      end
    end
  end

  task automatic queue_set(bit all_max);
    rx_pending.push_back(CMD_SET);
    for (int i = 0; i < SECRET_BYTES; i++)
      rx_pending.push_back(all_max ? 8'hff : 8'($urandom));
  endtask

  task automatic queue_hash(int fill);
    rx_pending.push_back(CMD_HASH);
    for (int i = 0; i < MESSAGE_BYTES; i++)
      rx_pending.push_back(fill >= 0 ? 8'(fill) : 8'($urandom));
  endtask

  task automatic wait_drained();
    while (rx_pending.size() != 0 || in_ch.valid) @(posedge clk);
    while (reply_expected.size() != 0) @(posedge clk);
  endtask

  initial begin
    int pick;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    // directed: zero secret hash, unknown commands, extremes, data bytes equal to commands
    queue_hash(0);
    rx_pending.push_back(8'h00);
    rx_pending.push_back(8'hff);
    rx_pending.push_back(8'h03);
    queue_set(1'b1);
    queue_hash(8'hff);
    rx_pending.push_back(CMD_SET);
    for (int i = 0; i < SECRET_BYTES; i++) rx_pending.push_back((i % 2) ? CMD_SET : CMD_HASH);
    queue_hash(CMD_SET);
    wait_drained();
    hold_tx = 1'b1;
    repeat (120) @(posedge clk);
    hold_tx = 1'b0;
    calm = 1'b1;
    queue_set(1'b0);
    queue_hash(-1);
    wait_drained();
    calm = 1'b0;
    while (rx_pending.size() < 232) begin
      pick = $urandom_range(9);
      if (pick < 4) queue_set(1'b0);
      else if (pick < 8) queue_hash(-1);
      else rx_pending.push_back(8'($urandom_range(3, 255)));
    end
    wait_drained();
    repeat (200) @(posedge clk);
    $display("Covered %0d acks, %0d digests, %0d reply beats checked.",
             n_acks, n_digests, n_beats);
    if (n_errors == 0 && reply_expected.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
